// ===== hw/rtl/capped_fair_share_rate_allocator_macros.svh =====
// Assertion macros shared by the rate allocator modules.
`ifndef CAPPED_FAIR_SHARE_RATE_ALLOCATOR_MACROS_SVH
`define CAPPED_FAIR_SHARE_RATE_ALLOCATOR_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CFSRA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define CFSRA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/cfsra_pkg.sv =====
// Types and constants of the capped fair-share rate allocator.
package cfsra_pkg;
	localparam int SLOTS = 4;
	localparam int IDX_W = 2;
	localparam int RATE_W = 32;
	localparam int CNT_W = 3;
	localparam int ADDR_W = 3;

	localparam logic [ADDR_W-1:0] REG_GLOBAL_LIMIT = 3'd0;
	localparam logic [ADDR_W-1:0] REG_CAP_ZERO = 3'd1;
	localparam logic [ADDR_W-1:0] REG_CAP_ONE = 3'd2;
	localparam logic [ADDR_W-1:0] REG_CAP_TWO = 3'd3;
	localparam logic [ADDR_W-1:0] REG_CAP_THREE = 3'd4;
	localparam logic [ADDR_W-1:0] REG_ACTIVE_MASK = 3'd5;

	typedef struct packed {
		logic [SLOTS-1:0] observed_mask;
		logic [RATE_W-1:0] speed_zero;
		logic [RATE_W-1:0] speed_one;
		logic [RATE_W-1:0] speed_two;
		logic [RATE_W-1:0] speed_three;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] backend;
		logic [RATE_W-1:0] assigned_limit;
		logic last;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_sel_share;
		logic cap_base;
		logic cap_share;
		logic scan_step;
		logic round_begin;
		logic round_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic trivial;
		logic div_done;
		logic idx_last;
		logic rem_zero;
		logic hungry_zero;
		logic step_drains;
		logic any_now;
		logic emit_take;
	} stat_t;
endpackage

// ===== hw/rtl/cfsra_div.sv =====
// Iterative restoring divider: 32-bit dividend by a small count, one bit per cycle.
module cfsra_div
	import cfsra_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RATE_W-1:0] num,
	input  logic [CNT_W-1:0]  den,
	output logic [RATE_W-1:0] quo,
	output logic              done
);
	`include "capped_fair_share_rate_allocator_macros.svh"

	logic [RATE_W-1:0] quo_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W-1:0]  rem_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[RATE_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[RATE_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

	`CFSRA_ASSERT(a_div_den_nonzero, !busy_q || den_q != '0, "divider running on zero count")
	`CFSRA_ASSERT_NEXT(a_div_no_restart, busy_q, !start, "divider restarted while busy")
endmodule

// ===== hw/rtl/cfsra_dp.sv =====
// Allocator datapath: config registers, per-backend state, divider and output register.
module cfsra_dp
	import cfsra_pkg::*;
#(
	parameter int NB_EFF = 4
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [RATE_W-1:0] cfg_data,
	input  in_word_t          in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output out_word_t         out_word,
	input  cmd_t              cmd,
	output stat_t             st
);
	`include "capped_fair_share_rate_allocator_macros.svh"

	localparam logic [SLOTS-1:0] NB_MASK = SLOTS'((1 << NB_EFF) - 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NB_EFF - 1);

	logic [RATE_W-1:0] gl_q;
	logic [RATE_W-1:0] cap_q [SLOTS];
	logic [SLOTS-1:0]  am_q;

	logic [RATE_W-1:0] spd_q [SLOTS];
	logic [RATE_W-1:0] capv_q [SLOTS];
	logic [RATE_W-1:0] asg_q [SLOTS];
	logic [SLOTS-1:0]  obs_q;
	logic [SLOTS-1:0]  act_q;
	logic [SLOTS-1:0]  hungry_q;
	logic [CNT_W-1:0]  act_cnt_q;
	logic [CNT_W-1:0]  hcnt_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] base_q;
	logic [RATE_W-1:0] share_q;
	logic [IDX_W-1:0]  idx_q;
	logic              any_q;
	logic              out_valid_q;
	out_word_t         out_word_q;

	logic [RATE_W-1:0] spd_in [SLOTS];
	logic [RATE_W-1:0] div_q;
	logic              div_done;
	logic [RATE_W-1:0] cur_cap, cur_asg, a_base, a_lim, a_scan, room, extra;
	logic              slow, elig, last_i, emit_take;

	assign spd_in[0] = in_word.speed_zero;
	assign spd_in[1] = in_word.speed_one;
	assign spd_in[2] = in_word.speed_two;
	assign spd_in[3] = in_word.speed_three;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gl_q <= '0;
			am_q <= '0;
			for (int i = 0; i < SLOTS; i++) cap_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_GLOBAL_LIMIT: gl_q <= cfg_data;
				REG_CAP_ZERO:     cap_q[0] <= cfg_data;
				REG_CAP_ONE:      cap_q[1] <= cfg_data;
				REG_CAP_TWO:      cap_q[2] <= cfg_data;
				REG_CAP_THREE:    cap_q[3] <= cfg_data;
				REG_ACTIVE_MASK:  am_q <= cfg_data[SLOTS-1:0];
				default: ;
			endcase
		end
	end

	cfsra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (cmd.div_sel_share ? rem_q : gl_q),
		.den    (cmd.div_sel_share ? hcnt_q : act_cnt_q),
		.quo    (div_q),
		.done   (div_done)
	);

	always_comb begin
		cur_cap = capv_q[idx_q];
		cur_asg = asg_q[idx_q];
		a_base  = base_q < cur_cap ? base_q : cur_cap;
		a_lim   = (base_q[RATE_W-1:3] == '0) ? RATE_W'(1) : (base_q >> 3);
		slow    = obs_q[idx_q] && (spd_q[idx_q] < (base_q >> 1));
		a_scan  = (slow && a_base > a_lim) ? a_lim : a_base;
		elig    = hungry_q[idx_q] && (cur_asg < cur_cap);
		room    = cur_cap - cur_asg;
		extra   = share_q < room ? share_q : room;
		if (extra > rem_q) extra = rem_q;
	end

	assign last_i    = idx_q == IDX_LAST;
	assign emit_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) idx_q <= '0;
			if (cmd.round_begin) any_q <= 1'b0;
			if (cmd.scan_step) idx_q <= last_i ? '0 : idx_q + 1'b1;
			if (cmd.round_step) begin
				idx_q <= (last_i || (elig && extra == rem_q)) ? '0 : idx_q + 1'b1;
				if (elig) any_q <= 1'b1;
			end
			if (cmd.emit && emit_take) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_i ? '0 : idx_q + 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			obs_q     <= in_word.observed_mask & NB_MASK;
			act_q     <= am_q & NB_MASK;
			act_cnt_q <= CNT_W'($countones(am_q & NB_MASK));
			hungry_q  <= '0;
			hcnt_q    <= '0;
			rem_q     <= gl_q;
			for (int i = 0; i < SLOTS; i++) begin
				spd_q[i]  <= spd_in[i];
				capv_q[i] <= (cap_q[i] == '0) ? gl_q : cap_q[i];
				asg_q[i]  <= '0;
			end
		end
		if (cmd.cap_base)
			base_q <= (div_q == '0) ? RATE_W'(1) : div_q;
		if (cmd.cap_share)
			share_q <= (div_q == '0) ? RATE_W'(1) : div_q;
		if (cmd.scan_step && act_q[idx_q]) begin
			asg_q[idx_q] <= a_scan;
			// base forced to 1 can hand out more than the limit: floor at 0
			rem_q        <= (a_scan > rem_q) ? '0 : rem_q - a_scan;
			if (!slow) begin
				hungry_q[idx_q] <= 1'b1;
				hcnt_q          <= hcnt_q + 1'b1;
			end
		end
		if (cmd.round_step && elig) begin
			asg_q[idx_q] <= cur_asg + extra;
			rem_q        <= rem_q - extra;
		end
		if (cmd.emit && emit_take) begin
			out_word_q.backend        <= idx_q;
			out_word_q.assigned_limit <= cur_asg;
			out_word_q.last           <= last_i;
		end
	end

	assign st.trivial     = (act_cnt_q == '0) || (gl_q == '0);
	assign st.div_done    = div_done;
	assign st.idx_last    = last_i;
	assign st.rem_zero    = rem_q == '0;
	assign st.hungry_zero = hcnt_q == '0;
	assign st.step_drains = elig && (extra == rem_q);
	assign st.any_now     = any_q || elig;
	assign st.emit_take   = emit_take;

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`CFSRA_ASSERT_NEXT(a_out_hold, out_valid_q && out_stall,
		out_valid_q && $stable(out_word_q), "stalled output word changed")
	`CFSRA_ASSERT(a_step_exclusive, !(cmd.scan_step && cmd.round_step) && !(cmd.emit && cmd.load),
		"conflicting datapath commands")
endmodule

// ===== hw/rtl/cfsra_ctrl.sv =====
// Allocator controller: sequences base division, scan, share rounds and output.
module cfsra_ctrl
	import cfsra_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output cmd_t  cmd,
	input  stat_t st
);
	`include "capped_fair_share_rate_allocator_macros.svh"

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_START     = 8'b0000_0010,
		ST_DIV_BASE  = 8'b0000_0100,
		ST_SCAN      = 8'b0000_1000,
		ST_CHECK     = 8'b0001_0000,
		ST_DIV_SHARE = 8'b0010_0000,
		ST_ROUND     = 8'b0100_0000,
		ST_EMIT      = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (st.trivial) state_d = ST_EMIT;
				else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV_BASE;
				end
			end
			ST_DIV_BASE: begin
				if (st.div_done) begin
					cmd.cap_base = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.idx_last) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (st.rem_zero || st.hungry_zero) state_d = ST_EMIT;
				else begin
					cmd.div_start     = 1'b1;
					cmd.div_sel_share = 1'b1;
					cmd.round_begin   = 1'b1;
					state_d           = ST_DIV_SHARE;
				end
			end
			ST_DIV_SHARE: begin
				cmd.div_sel_share = 1'b1;
				if (st.div_done) begin
					cmd.cap_share = 1'b1;
					state_d       = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
				if (st.step_drains) state_d = ST_EMIT;
				else if (st.idx_last) state_d = st.any_now ? ST_CHECK : ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (st.emit_take && st.idx_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign in_stall = state_q != ST_IDLE;

	`CFSRA_ASSERT_NEXT(a_start_div, cmd.div_start,
		state_q == ST_DIV_BASE || state_q == ST_DIV_SHARE, "division start lost")
	`CFSRA_ASSERT_NEXT(a_accept_start, in_valid && !in_stall,
		state_q == ST_START, "accepted word not started")
endmodule

// ===== hw/rtl/capped_fair_share_rate_allocator.sv =====
// Capped fair-share rate allocator top level: controller plus datapath.
// Usage: software writes global_limit, the four caps and active_mask through
// cfg_we/cfg_addr/cfg_data while the block is idle. Each input word carries the
// observed mask and four observed speeds; the block answers with NUM_BACKENDS
// output words, NUM_BACKENDS clamped to 1..4, one per backend in index order,
// last set on the final one. Sequence: the base division runs in the shared
// divider, one quotient bit per cycle; then the scan steps through the
// backends; then each share round divides the remainder in the divider and
// steps through the backends; then the output words are loaded one by one.
// in_stall is high from acceptance until the last output word is loaded into
// the output register, so one word is worked on at a time; the next input
// word may be taken while the last output word still waits.
// While out_valid and out_stall are high the output word holds and emit waits.
// Reset clears the config registers and out_valid and returns the block to idle.
module capped_fair_share_rate_allocator
	import cfsra_pkg::*;
#(
	parameter int NUM_BACKENDS = 4
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [RATE_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_word_t          in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output out_word_t         out_word
);
	localparam int NB_EFF = (NUM_BACKENDS < 1) ? 1 :
		((NUM_BACKENDS > SLOTS) ? SLOTS : NUM_BACKENDS);

	cmd_t  cmd;
	stat_t st;

	cfsra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.st       (st)
	);

	cfsra_dp #(.NB_EFF(NB_EFF)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cmd       (cmd),
		.st        (st)
	);
endmodule

// ===== dv/tb.sv =====
// Testbench for the capped fair-share rate allocator: self-checking against a built-in predictor.
`timescale 1ns / 100ps
module tb;
	import cfsra_pkg::*;

	localparam int NB = 4;
	localparam longint LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ADDR_W-1:0] cfg_addr = '0;
	logic [RATE_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;

	logic [31:0] glimit;
	logic [31:0] caps [NB];
	logic [3:0] amask;
	out_word_t limits_q[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;
	longint cycles = 0;

	capped_fair_share_rate_allocator #(.NUM_BACKENDS(NB)) dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall);

	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (limits_q.size() == 0) begin
				$error("unexpected word %h", out_word);
				errors++;
			end else begin
				e = limits_q.pop_front();
				if (e.backend !== out_word.backend) begin
					$error("backend exp %0d got %0d", e.backend, out_word.backend);
					errors++;
				end
				if (e.assigned_limit !== out_word.assigned_limit) begin
					$error("assigned_limit exp %0d got %0d", e.assigned_limit,
						out_word.assigned_limit);
					errors++;
				end
				if (e.last !== out_word.last) begin
					$error("last exp %0d got %0d", e.last, out_word.last);
					errors++;
				end
			end
		end
	end

	task automatic predict_limits(input in_word_t w);
		longint unsigned asg [NB];
		longint unsigned capv [NB];
		bit act [NB];
		bit hungry [NB];
		longint unsigned base, used, rem, share, room, extra, lim, a, spd;
		int nact, nh;
		bit any, stop;
		out_word_t o;
		nact = 0;
		nh = 0;
		used = 0;
		for (int i = 0; i < NB; i++) begin
			asg[i] = 0;
			act[i] = amask[i];
			hungry[i] = 0;
			capv[i] = (caps[i] == 0) ? glimit : caps[i];
			if (act[i]) nact++;
		end
		if (nact != 0 && glimit != 0) begin
			base = glimit / nact;
			if (base < 1) base = 1;
			for (int i = 0; i < NB; i++) begin
				if (act[i]) begin
					case (i)
						0: spd = w.speed_zero;
						1: spd = w.speed_one;
						2: spd = w.speed_two;
						default: spd = w.speed_three;
					endcase
					a = (base < capv[i]) ? base : capv[i];
					if (w.observed_mask[i] && spd < base / 2) begin
						lim = base / 8;
						if (lim < 1) lim = 1;
						if (a > lim) a = lim;
					end else begin
						hungry[i] = 1;
						nh++;
					end
					asg[i] = a;
					used += a;
				end
			end
			rem = (used < glimit) ? glimit - used : 0;
			stop = 0;
			while (rem > 0 && nh > 0 && !stop) begin
				any = 0;
				share = rem / nh;
				if (share < 1) share = 1;
				for (int i = 0; i < NB; i++) begin
					if (rem != 0 && hungry[i] && asg[i] < capv[i]) begin
						room = capv[i] - asg[i];
						extra = (share < room) ? share : room;
						if (extra > rem) extra = rem;
						asg[i] += extra;
						rem -= extra;
						any = 1;
					end
				end
				if (!any) stop = 1;
			end
		end
		for (int i = 0; i < NB; i++) begin
			o.backend = IDX_W'(i);
			o.assigned_limit = asg[i][31:0];
			o.last = (i == NB - 1);
			limits_q.push_back(o);
		end
	endtask

	task automatic send_word(input in_word_t w);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		predict_limits(w);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (limits_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GLOBAL_LIMIT: glimit = v;
			REG_CAP_ZERO: caps[0] = v;
			REG_CAP_ONE: caps[1] = v;
			REG_CAP_TWO: caps[2] = v;
			REG_CAP_THREE: caps[3] = v;
			REG_ACTIVE_MASK: amask = v[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_all(input logic [31:0] g, input logic [31:0] c0, input logic [31:0] c1,
			input logic [31:0] c2, input logic [31:0] c3, input logic [3:0] m);
		drain();
		write_reg(REG_GLOBAL_LIMIT, g);
		write_reg(REG_CAP_ZERO, c0);
		write_reg(REG_CAP_ONE, c1);
		write_reg(REG_CAP_TWO, c2);
		write_reg(REG_CAP_THREE, c3);
		write_reg(REG_ACTIVE_MASK, {28'd0, m});
	endtask

	function automatic logic [31:0] rnd_rate();
		case ($urandom_range(4))
			0: return $urandom_range(3);
			1: return $urandom_range(100);
			2: return $urandom_range(100000);
			3: return 32'hFFFFFFFF - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	function automatic in_word_t rnd_word();
		in_word_t w;
		w.observed_mask = SLOTS'($urandom);
		w.speed_zero = rnd_rate();
		w.speed_one = rnd_rate();
		w.speed_two = rnd_rate();
		w.speed_three = rnd_rate();
		return w;
	endfunction

	task automatic test_directed();
		in_word_t w;
		send_word('0);
		set_all(0, 0, 0, 0, 0, 4'hF);
		send_word(rnd_word());
		set_all(1000, 0, 0, 0, 0, 4'h0);
		send_word(rnd_word());
		set_all(1000, 0, 0, 0, 0, 4'hF);
		w = '{4'hF, 32'd0, 32'd1000, 32'd100, 32'hFFFFFFFF};
		send_word(w);
		w.observed_mask = 4'h0;
		send_word(w);
		set_all(1000, 100, 0, 50, 300, 4'hB);
		w = '{4'h1, 32'd10, 32'd0, 32'd0, 32'd0};
		send_word(w);
		send_word('{4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
		set_all(3, 0, 0, 0, 0, 4'hF);
		send_word('{4'hF, 32'd0, 32'd0, 32'd0, 32'd0});
		send_word('0);
		set_all(32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 32'h80000000, 4'hF);
		send_word('{4'h5, 32'd0, 32'h7FFFFFFF, 32'h1FFFFFFF, 32'd5});
		send_word('0);
		drain();
		write_reg(3'd6, 32'h12345678);
		write_reg(3'd7, 32'hFFFFFFFF);
		send_word(rnd_word());
	endtask

	task automatic test_random(input int n, input int si, input int rs);
		send_idle = si;
		recv_stall = rs;
		for (int k = 0; k < n; k++) begin
			if (k % 10 == 0)
				set_all(rnd_rate(), ($urandom_range(2) == 0) ? 0 : rnd_rate(),
					($urandom_range(2) == 0) ? 0 : rnd_rate(),
					($urandom_range(2) == 0) ? 0 : rnd_rate(),
					($urandom_range(2) == 0) ? 0 : rnd_rate(), 4'($urandom));
			send_word(rnd_word());
		end
	endtask

	initial begin
		glimit = 0;
		amask = 0;
		for (int i = 0; i < NB; i++) caps[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(80, 0, 0);
		test_random(80, 48, 0);
		test_random(80, 0, 48);
		test_random(80, 7, 7);
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cfsra_pkg.sv
hw/rtl/cfsra_div.sv
hw/rtl/cfsra_dp.sv
hw/rtl/cfsra_ctrl.sv
hw/rtl/capped_fair_share_rate_allocator.sv
dv/tb.sv
